@@ rtl/core/halton_subpixel_jitter_assert.svh @@
// ----------------------------------------------------------------------------
// Halton subpixel jitter assertion macros
// Concurrent checks clocked on clk and reset by arst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef HALTON_SUBPIXEL_JITTER_ASSERT_SVH
`define HALTON_SUBPIXEL_JITTER_ASSERT_SVH

// same-cycle implication
`define HSJ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSJ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hsj_pkg.sv @@
// ----------------------------------------------------------------------------
// hsj_pkg
// Shared constants, types and helpers for the Halton subpixel jitter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsj_pkg;

	localparam int MAX_PERIOD = 64;
	localparam int FRAC_BITS  = 24;

	localparam int JIT_W    = FRAC_BITS;
	localparam int OFS_W    = FRAC_BITS + 1;
	localparam int IDX_W    = $clog2(MAX_PERIOD + 1);
	// base 3 numerator/denominator; denominator reaches 3^4 for indexes up to 64
	localparam int N3_W     = 7;
	localparam int PERIOD_W = 7;
	localparam int SIZE_W   = 15;
	localparam int DIV_W    = 32;
	localparam int DSR_W    = SIZE_W;
	localparam int CNT_W    = $clog2(DIV_W);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_JITTER_ON     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_JITTER_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT   = 3'd3;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd8;
	localparam logic [SIZE_W-1:0]   WIDTH_RST  = 15'd1920;
	localparam logic [SIZE_W-1:0]   HEIGHT_RST = 15'd1080;

	localparam logic [JIT_W-1:0] HALF = {1'b1, {(JIT_W-1){1'b0}}};

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MOD   = 7'b0000010,
		S_DIGIT = 7'b0000100,
		S_H3    = 7'b0001000,
		S_OFSX  = 7'b0010000,
		S_OFSY  = 7'b0100000,
		S_HOLD  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// magnitude of 2*j for a signed jitter value
	function automatic logic [OFS_W-1:0] twice_mag(input logic [JIT_W-1:0] j);
		logic [OFS_W-1:0] t;
		t = {j, 1'b0};
		return j[JIT_W-1] ? (~t + 1'b1) : t;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsj_div.sv @@
// ----------------------------------------------------------------------------
// hsj_div
// Shared restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "halton_subpixel_jitter_assert.svh"

module hsj_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [hsj_pkg::DIV_W-1:0] dividend,
	input  logic [hsj_pkg::DSR_W-1:0] divisor,
	output hsj_pkg::div_stat_t        stat,
	output logic [hsj_pkg::DIV_W-1:0] quotient,
	output logic [hsj_pkg::DSR_W-1:0] remainder
);
	import hsj_pkg::*;

	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   trial;
	logic             fits;
	logic [DSR_W:0]   diff;
	logic             last;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};
	assign last  = cnt_q == CNT_W'(DIV_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift into the dividend register from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	`HSJ_ASSERT_NXT(a_start_busy, start, busy_q, "divider did not start")
	`HSJ_ASSERT_NXT(a_last_done, busy_q && last && !start, done_q && !busy_q,
		"divider missed its final step")
	`HSJ_ASSERT_NOW(a_done_idle, done_q, !busy_q, "divider done while busy")

endmodule

`default_nettype wire

@@ rtl/core/halton_subpixel_jitter.sv @@
// ----------------------------------------------------------------------------
// halton_subpixel_jitter
// Halton base 2 / base 3 subpixel jitter and projection offsets per frame.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. When jitter is on, the period
// modulo, the base 3 fraction and the two offset quotients each pass through
// the one shared 32-step divider, with the base 2 / base 3 digit extraction
// between the modulo and the base 3 fraction. With jitter off the divider is
// not used and the block goes straight to its hold state. A finished result
// waits in the output register, and the next frame number may be taken
// meanwhile. Configuration writes must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "halton_subpixel_jitter_assert.svh"

module halton_subpixel_jitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hsj_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hsj_pkg::CFG_DAT_W-1:0]        cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [31:0]                          frame_number,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [hsj_pkg::JIT_W-1:0]     jitter_x,
	output logic signed [hsj_pkg::JIT_W-1:0]     jitter_y,
	output logic signed [hsj_pkg::OFS_W-1:0]     offset_x,
	output logic signed [hsj_pkg::OFS_W-1:0]     offset_y
);
	import hsj_pkg::*;

	// configuration
	logic                jitter_on_q;
	logic [PERIOD_W-1:0] jitter_period_q;
	logic [SIZE_W-1:0]   view_width_q;
	logic [SIZE_W-1:0]   view_height_q;

	state_t              state_q;
	logic                st_q;
	logic [DIV_W-1:0]    frame_q;

	// digit loop
	logic [IDX_W-1:0]    v_q;
	logic [IDX_W-1:0]    b_q;
	logic [JIT_W-1:0]    h2_q;
	logic [JIT_W-1:0]    w2_q;
	logic [N3_W-1:0]     num3_q;
	logic [N3_W-1:0]     den3_q;

	logic [JIT_W-1:0]    jx_q;
	logic [JIT_W-1:0]    jy_q;
	logic [OFS_W-1:0]    ox_q;
	logic [OFS_W-1:0]    oy_q;
	logic                out_valid_q;

	logic [IDX_W-1:0]    period_eff;
	logic [SIZE_W-1:0]   width_eff;
	logic [SIZE_W-1:0]   height_eff;
	logic                in_take;
	logic                can_load;
	logic                hold_load;
	logic                div_start;

	logic [12:0]         prod3;
	logic [IDX_W-1:0]    q3;
	logic [IDX_W-1:0]    q3x3;
	logic [1:0]          d3;

	logic [DIV_W-1:0]    dv_dividend;
	logic [DSR_W-1:0]    dv_divisor;
	div_stat_t           dv_stat;
	logic [DIV_W-1:0]    dv_quot;
	logic [DSR_W-1:0]    dv_rem;
	logic [OFS_W-1:0]    q_ofs;
	logic [OFS_W-1:0]    q_ofs_neg;

	always_comb begin
		if (jitter_period_q == '0) begin
			period_eff = IDX_W'(1);
		end else if (jitter_period_q > PERIOD_W'(MAX_PERIOD)) begin
			period_eff = IDX_W'(MAX_PERIOD);
		end else begin
			period_eff = IDX_W'(jitter_period_q);
		end
	end

	assign width_eff  = (view_width_q == '0) ? SIZE_W'(1) : view_width_q;
	assign height_eff = (view_height_q == '0) ? SIZE_W'(1) : view_height_q;

	assign in_stall  = state_q != S_IDLE;
	assign in_take   = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign hold_load = state_q == S_HOLD && can_load;

	// divider kicks off on the cycle after each step that needs it
	assign div_start = (in_take && jitter_on_q) ||
		(state_q == S_DIGIT && v_q == '0 && b_q == '0) ||
		(dv_stat.done && (state_q == S_H3 || state_q == S_OFSX));

	// v/3 by reciprocal, exact for v below 128
	assign prod3 = 13'(v_q) * 13'd43;
	assign q3    = IDX_W'(prod3[12:7]);
	assign q3x3  = IDX_W'({q3, 1'b0}) + q3;
	assign d3    = 2'(v_q - q3x3);

	always_comb begin
		case (state_q)
			S_H3: begin
				dv_dividend = DIV_W'({num3_q, {FRAC_BITS{1'b0}}});
				dv_divisor  = DSR_W'(den3_q);
			end
			S_OFSX: begin
				dv_dividend = DIV_W'(twice_mag(jx_q));
				dv_divisor  = width_eff;
			end
			S_OFSY: begin
				dv_dividend = DIV_W'(twice_mag(jy_q));
				dv_divisor  = height_eff;
			end
			default: begin
				dv_dividend = frame_q;
				dv_divisor  = DSR_W'(period_eff);
			end
		endcase
	end

	hsj_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (st_q),
		.dividend  (dv_dividend),
		.divisor   (dv_divisor),
		.stat      (dv_stat),
		.quotient  (dv_quot),
		.remainder (dv_rem)
	);

	assign q_ofs     = dv_quot[OFS_W-1:0];
	assign q_ofs_neg = ~q_ofs + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_on_q     <= 1'b1;
			jitter_period_q <= PERIOD_RST;
			view_width_q    <= WIDTH_RST;
			view_height_q   <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_JITTER_ON:     jitter_on_q     <= cfg_wdata[0];
				CFG_JITTER_PERIOD: jitter_period_q <= cfg_wdata[PERIOD_W-1:0];
				CFG_VIEW_WIDTH:    view_width_q    <= cfg_wdata[SIZE_W-1:0];
				CFG_VIEW_HEIGHT:   view_height_q   <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= div_start;
			out_valid_q <= hold_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (jitter_on_q) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_MOD: begin
					if (dv_stat.done) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (v_q == '0 && b_q == '0) begin
						state_q <= S_H3;
					end
				end
				S_H3: begin
					if (dv_stat.done) begin
						state_q <= S_OFSX;
					end
				end
				S_OFSX: begin
					if (dv_stat.done) begin
						state_q <= S_OFSY;
					end
				end
				S_OFSY: begin
					if (dv_stat.done) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					frame_q <= frame_number;
					jx_q    <= '0;
					jy_q    <= '0;
					ox_q    <= '0;
					oy_q    <= '0;
				end
			end
			S_MOD: begin
				if (dv_stat.done) begin
					v_q    <= dv_rem[IDX_W-1:0] + 1'b1;
					b_q    <= dv_rem[IDX_W-1:0] + 1'b1;
					h2_q   <= '0;
					w2_q   <= HALF;
					num3_q <= '0;
					den3_q <= N3_W'(1);
				end
			end
			S_DIGIT: begin
				if (v_q == '0 && b_q == '0) begin
					jx_q <= h2_q ^ HALF;
				end
				if (b_q != '0) begin
					if (b_q[0]) begin
						h2_q <= h2_q + w2_q;
					end
					w2_q <= w2_q >> 1;
					b_q  <= b_q >> 1;
				end
				if (v_q != '0) begin
					num3_q <= N3_W'({num3_q, 1'b0}) + num3_q + N3_W'(d3);
					den3_q <= N3_W'({den3_q, 1'b0}) + den3_q;
					v_q    <= q3;
				end
			end
			S_H3: begin
				if (dv_stat.done) begin
					jy_q <= dv_quot[JIT_W-1:0] ^ HALF;
				end
			end
			S_OFSX: begin
				if (dv_stat.done) begin
					ox_q <= jx_q[JIT_W-1] ? q_ofs_neg : q_ofs;
				end
			end
			S_OFSY: begin
				if (dv_stat.done) begin
					oy_q <= jy_q[JIT_W-1] ? q_ofs_neg : q_ofs;
				end
			end
			S_HOLD: begin
				if (can_load) begin
					jitter_x <= jx_q;
					jitter_y <= jy_q;
					offset_x <= ox_q;
					offset_y <= oy_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`HSJ_ASSERT_NOW(a_div_done_state, dv_stat.done,
		state_q == S_MOD || state_q == S_H3 || state_q == S_OFSX || state_q == S_OFSY,
		"divider finished outside a divide step")
	`HSJ_ASSERT_NOW(a_frac3_proper, state_q == S_DIGIT, num3_q < den3_q,
		"base 3 numerator not below denominator")
	`HSJ_ASSERT_NXT(a_hold_load, state_q == S_HOLD && can_load,
		out_valid_q && state_q == S_IDLE, "result not presented after hold")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for halton_subpixel_jitter. Sends frame numbers through the
// valid/stall input channel under several register settings and checks every
// output transfer against a predicted jitter pair and projection offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import hsj_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int RANDOM_PHASES = 18;
	localparam int PHASE_FRAMES  = 100;
	localparam int CALM_PHASE    = 5;
	// first register index with nothing behind it
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

	typedef struct packed {
		logic [JIT_W-1:0] jx;
		logic [JIT_W-1:0] jy;
		logic [OFS_W-1:0] ox;
		logic [OFS_W-1:0] oy;
	} jitter_t;

	class jitter_scoreboard;
		logic                 jit_on;
		logic [PERIOD_W-1:0]  period;
		logic [SIZE_W-1:0]    width;
		logic [SIZE_W-1:0]    height;
		jitter_t              expected_jitter[$];
		int                   mismatches;
		int                   results_seen;

		function new();
			jit_on       = 1'b1;
			period       = PERIOD_RST;
			width        = WIDTH_RST;
			height       = HEIGHT_RST;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
			case (idx)
				CFG_JITTER_ON:     jit_on = d[0];
				CFG_JITTER_PERIOD: period = d[PERIOD_W-1:0];
				CFG_VIEW_WIDTH:    width  = d[SIZE_W-1:0];
				CFG_VIEW_HEIGHT:   height = d[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// exact radical inverse, floored to FRAC_BITS fractional bits
		function longint unsigned radical_frac(longint unsigned base, longint unsigned seq);
			longint unsigned num;
			longint unsigned den;
			num = 0;
			den = 1;
			while (seq > 0) begin
				num = num * base + seq % base;
				den = den * base;
				seq = seq / base;
			end
			return (num << FRAC_BITS) / den;
		endfunction

		// 2*j / size, quotient truncated toward zero
		function logic [OFS_W-1:0] scaled_offset(longint j, logic [SIZE_W-1:0] size);
			longint d;
			longint t;
			longint m;
			d = (size == 0) ? 1 : longint'(size);
			t = 2 * j;
			m = ((t < 0) ? -t : t) / d;
			if (t < 0)
				m = -m;
			return m[OFS_W-1:0];
		endfunction

		function jitter_t predict_jitter(logic [31:0] frame);
			jitter_t         r;
			longint unsigned p;
			longint unsigned seq;
			longint          half;
			longint          jx;
			longint          jy;
			r = '0;
			p = period;
			if (p == 0)
				p = 1;
			if (p > MAX_PERIOD)
				p = MAX_PERIOD;
			if (jit_on) begin
				seq  = longint'(frame) % p + 1;
				half = longint'(1) << (FRAC_BITS - 1);
				jx   = longint'(radical_frac(2, seq)) - half;
				jy   = longint'(radical_frac(3, seq)) - half;
				r.jx = jx[JIT_W-1:0];
				r.jy = jy[JIT_W-1:0];
				r.ox = scaled_offset(jx, width);
				r.oy = scaled_offset(jy, height);
			end
			return r;
		endfunction

		function void note_frame(logic [31:0] frame);
			expected_jitter.push_back(predict_jitter(frame));
		endfunction

		function int pending();
			return expected_jitter.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [JIT_W-1:0] jx, logic [JIT_W-1:0] jy,
				logic [OFS_W-1:0] ox, logic [OFS_W-1:0] oy);
			jitter_t want;
			results_seen++;
			if (expected_jitter.size() == 0) begin
				report($sformatf("result %0d arrived with no frame outstanding",
					results_seen));
			end else begin
				want = expected_jitter.pop_front();
				if (jx !== want.jx)
					report($sformatf("result %0d jitter_x got %0d expected %0d",
						results_seen, $signed(jx), $signed(want.jx)));
				if (jy !== want.jy)
					report($sformatf("result %0d jitter_y got %0d expected %0d",
						results_seen, $signed(jy), $signed(want.jy)));
				if (ox !== want.ox)
					report($sformatf("result %0d offset_x got %0d expected %0d",
						results_seen, $signed(ox), $signed(want.ox)));
				if (oy !== want.oy)
					report($sformatf("result %0d offset_y got %0d expected %0d",
						results_seen, $signed(oy), $signed(want.oy)));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           frame_number = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [JIT_W-1:0]      jitter_x;
	logic [JIT_W-1:0]      jitter_y;
	logic [OFS_W-1:0]      offset_x;
	logic [OFS_W-1:0]      offset_y;
	logic                  calm = 1'b0;
	int                    cycle_count = 0;
	jitter_scoreboard      sb = new();

	halton_subpixel_jitter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.jitter_x     (jitter_x),
		.jitter_y     (jitter_y),
		.offset_x     (offset_x),
		.offset_y     (offset_y)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output side: check each transfer, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(jitter_x, jitter_y, offset_x, offset_y);
		out_stall <= !calm && ($urandom_range(0, 99) < 34);
	end

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task end_writes();
		cfg_we <= 1'b0;
	endtask

	task send_frame(logic [31:0] f);
		if (!calm && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 160)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		frame_number <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_frame(f);
	endtask

	task finish_group();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 7'd1;
			2:       return 7'd64;
			3:       return PERIOD_W'($urandom_range(65, 127));
			default: return PERIOD_W'($urandom_range(1, 64));
		endcase
	endfunction

	function logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 15'd1;
			2:       return 15'd16384;
			3:       return SIZE_W'($urandom_range(16385, 32767));
			default: return SIZE_W'($urandom_range(1, 16384));
		endcase
	endfunction

	function logic [31:0] pick_frame();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 200);
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 200);
			default: return $urandom;
		endcase
	endfunction

	task randomize_config();
		logic [CFG_DAT_W-1:0] d;
		if ($urandom_range(0, 1)) begin
			d    = CFG_DAT_W'($urandom);
			d[0] = ($urandom_range(0, 99) < 85);
			write_reg(CFG_JITTER_ON, d);
		end
		if ($urandom_range(0, 1)) begin
			d = CFG_DAT_W'($urandom);
			d[PERIOD_W-1:0] = pick_period();
			write_reg(CFG_JITTER_PERIOD, d);
		end
		if ($urandom_range(0, 1))
			write_reg(CFG_VIEW_WIDTH, pick_size());
		if ($urandom_range(0, 1))
			write_reg(CFG_VIEW_HEIGHT, pick_size());
		if ($urandom_range(0, 9) == 0)
			write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 3)),
				CFG_DAT_W'($urandom));
		end_writes();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: period 8, 1920 x 1080
		send_frame(32'd0);
		send_frame(32'd7);
		send_frame(32'hFFFF_FFFF);
		send_frame(32'h8000_0000);
		send_frame(32'd1);
		finish_group();

		// period above maximum saturates; unit viewport gives the largest offsets
		write_reg(CFG_JITTER_PERIOD, 15'd127);
		write_reg(CFG_VIEW_WIDTH, 15'd1);
		write_reg(CFG_VIEW_HEIGHT, 15'd1);
		end_writes();
		send_frame(32'd63);
		send_frame(32'd64);
		send_frame(32'd0);
		finish_group();

		// zero period and zero viewport both act as one
		write_reg(CFG_JITTER_PERIOD, 15'd0);
		write_reg(CFG_VIEW_WIDTH, 15'd0);
		write_reg(CFG_VIEW_HEIGHT, 15'd0);
		end_writes();
		send_frame(32'd5);
		send_frame(32'hFFFF_FFFF);
		finish_group();

		write_reg(CFG_JITTER_PERIOD, 15'd64);
		write_reg(CFG_VIEW_WIDTH, 15'd32767);
		write_reg(CFG_VIEW_HEIGHT, 15'd16384);
		end_writes();
		send_frame(32'd63);
		send_frame(32'd62);
		send_frame(32'd40);
		finish_group();

		// only bit 0 of the enable counts: this turns jitter off
		write_reg(CFG_JITTER_ON, 15'd2);
		end_writes();
		send_frame(32'd0);
		send_frame(32'hFFFF_FFFF);
		finish_group();

		// writes above the last register must not alias onto real ones
		write_reg(CFG_JITTER_ON, 15'd1);
		write_reg(CFG_JITTER_PERIOD, 15'd3);
		write_reg(CFG_FIRST_UNUSED, 15'd0);
		write_reg(CFG_FIRST_UNUSED + 3'd1, 15'd0);
		write_reg(CFG_FIRST_UNUSED + 3'd2, 15'd1);
		write_reg(CFG_FIRST_UNUSED + 3'd3, 15'd1);
		end_writes();
		send_frame(32'd0);
		send_frame(32'd1);
		send_frame(32'd2);
		send_frame(32'd3);
		finish_group();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm <= (ph == CALM_PHASE);
			randomize_config();
			for (int n = 0; n < PHASE_FRAMES; n++)
				send_frame(pick_frame());
			finish_group();
		end
		calm <= 1'b0;

		// room for any stray transfer after the last expected one
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hsj_pkg.sv
rtl/core/hsj_div.sv
rtl/core/halton_subpixel_jitter.sv
verif/tb_top.sv
